// ----- rtl/cdq_pkg.sv -----
package cdq_pkg;

  localparam int STAMP_W = 6;

  typedef enum logic [1:0] {
    KIND_PUSH    = 2'd0,
    KIND_POP_ANY = 2'd1,
    KIND_POP_C0  = 2'd2,
    KIND_POP_C1  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

// ----- rtl/cdq_mem.sv -----
module cdq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 14
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/two_class_age_ordered_fifo_unit.sv -----
// Channel  Direction  Handshake             Word fields
// -------  ---------  --------------------  ---------------------------------------------
// in       input      in_valid / in_ready   kind, item_class, item_data
// out      output     out_valid / out_ready status, popped_class, popped_data,
//                                           all_empty, class0_empty, class1_empty
//
// Each operation is accepted in ST_IDLE, which issues the head reads of both
// class memories, and then runs in ST_EXEC, which compares the stamps, pops or pushes, and
// loads the output register. The registered read port of each memory sets this split.
// Reset (rst, synchronous) empties both queues and clears the arrival stamp; the
// memories are not cleared. A stalled output word holds the execute cycle, so no
// new word is accepted until the previous result can be loaded.
module two_class_age_ordered_fifo_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int DATA_WIDTH  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            kind,
  input  logic                  item_class,
  input  logic [DATA_WIDTH-1:0] item_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic                  popped_class,
  output logic [DATA_WIDTH-1:0] popped_data,
  output logic                  all_empty,
  output logic                  class0_empty,
  output logic                  class1_empty
);

  import cdq_pkg::*;

  localparam int AW      = $clog2(QUEUE_DEPTH);
  localparam int ENTRY_W = DATA_WIDTH + STAMP_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

  // Pointers: index into the memory plus a lap bit that tells full from empty.
  logic [AW-1:0] rd_idx [2];
  logic          rd_lap [2];
  logic [AW-1:0] wr_idx [2];
  logic          wr_lap [2];
  logic [AW-1:0] rd_idx_next [2];
  logic          rd_lap_next [2];
  logic [AW-1:0] wr_idx_next [2];
  logic          wr_lap_next [2];

  logic [STAMP_W-1:0] stamp;
  logic [STAMP_W-1:0] stamp_next;

  state_t state;

  // operation held for the execute cycle
  kind_t                 op_kind;
  logic                  op_class;
  logic [DATA_WIDTH-1:0] op_data;

  logic                  in_fire;
  logic                  exec_fire;
  logic [1:0]            mem_we;
  logic [ENTRY_W-1:0]    head0;
  logic [ENTRY_W-1:0]    head1;
  logic [ENTRY_W-1:0]    wentry;

  logic                  empty [2];
  logic                  full  [2];
  logic                  sel_valid;
  logic                  sel;
  logic [STAMP_W-1:0]    stamp_diff;
  status_t               status_next;
  logic [DATA_WIDTH-1:0] pdata_next;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  // hold execute while the output register still carries an untaken word
  assign exec_fire = (state == ST_EXEC) && (!out_valid || out_ready);

  assign wentry = {op_data, stamp};

  cdq_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W)) u_mem0 (
    .clk   (clk),
    .we    (mem_we[0]),
    .waddr (wr_idx[0]),
    .wdata (wentry),
    .re    (in_fire),
    .raddr (rd_idx[0]),
    .rdata (head0)
  );

  cdq_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W)) u_mem1 (
    .clk   (clk),
    .we    (mem_we[1]),
    .waddr (wr_idx[1]),
    .wdata (wentry),
    .re    (in_fire),
    .raddr (rd_idx[1]),
    .rdata (head1)
  );

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      empty[c] = (rd_idx[c] == wr_idx[c]) && (rd_lap[c] == wr_lap[c]);
      full[c]  = (rd_idx[c] == wr_idx[c]) && (rd_lap[c] != wr_lap[c]);
    end
  end

  // Pick the class to pop. Class 0 wins only when its stamp is strictly older
  // by wraparound compare; a tie goes to class 1.
  assign stamp_diff = head0[STAMP_W-1:0] - head1[STAMP_W-1:0];

  always_comb begin
    sel_valid = 1'b0;
    sel       = 1'b0;
    unique case (op_kind)
      KIND_PUSH: begin
        sel_valid = 1'b0;
      end
      KIND_POP_ANY: begin
        priority if (!empty[0] && !empty[1]) begin
          sel_valid = 1'b1;
          sel       = !stamp_diff[STAMP_W-1];
        end else if (!empty[0]) begin
          sel_valid = 1'b1;
          sel       = 1'b0;
        end else if (!empty[1]) begin
          sel_valid = 1'b1;
          sel       = 1'b1;
        end else begin
          sel_valid = 1'b0;
        end
      end
      KIND_POP_C0: begin
        sel_valid = !empty[0];
        sel       = 1'b0;
      end
      KIND_POP_C1: begin
        sel_valid = !empty[1];
        sel       = 1'b1;
      end
      default: begin
        sel_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      rd_idx_next[c] = rd_idx[c];
      rd_lap_next[c] = rd_lap[c];
      wr_idx_next[c] = wr_idx[c];
      wr_lap_next[c] = wr_lap[c];
    end
    stamp_next  = stamp;
    mem_we      = 2'b00;
    status_next = STATUS_OK;
    pdata_next  = '0;

    if (op_kind == KIND_PUSH) begin
      if (full[op_class]) begin
        status_next = STATUS_FULL;
      end else begin
        mem_we[op_class] = exec_fire;
        // advance write pointer, flip lap at the end of the memory
        if (wr_idx[op_class] == LAST_IDX) begin
          wr_idx_next[op_class] = '0;
          wr_lap_next[op_class] = !wr_lap[op_class];
        end else begin
          wr_idx_next[op_class] = wr_idx[op_class] + 1'b1;
        end
        stamp_next = stamp + 1'b1;
      end
    end else if (!sel_valid) begin
      status_next = STATUS_EMPTY;
    end else begin
      pdata_next = sel ? head1[ENTRY_W-1:STAMP_W] : head0[ENTRY_W-1:STAMP_W];
      if (rd_idx[sel] == LAST_IDX) begin
        rd_idx_next[sel] = '0;
        rd_lap_next[sel] = !rd_lap[sel];
      end else begin
        rd_idx_next[sel] = rd_idx[sel] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_fire) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // capture the operation word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_kind  <= kind_t'(kind);
      op_class <= item_class;
      op_data  <= item_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 2; c++) begin
        rd_idx[c] <= '0;
        rd_lap[c] <= 1'b0;
        wr_idx[c] <= '0;
        wr_lap[c] <= 1'b0;
      end
      stamp <= '0;
    end else if (exec_fire) begin
      for (int c = 0; c < 2; c++) begin
        rd_idx[c] <= rd_idx_next[c];
        rd_lap[c] <= rd_lap_next[c];
        wr_idx[c] <= wr_idx_next[c];
        wr_lap[c] <= wr_lap_next[c];
      end
      stamp <= stamp_next;
    end
  end

  // output register: set on execute, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      status       <= status_next;
      popped_class <= (status_next == STATUS_OK) && (op_kind != KIND_PUSH) && sel;
      popped_data  <= pdata_next;
      class0_empty <= (rd_idx_next[0] == wr_idx_next[0]) &&
                      (rd_lap_next[0] == wr_lap_next[0]);
      class1_empty <= (rd_idx_next[1] == wr_idx_next[1]) &&
                      (rd_lap_next[1] == wr_lap_next[1]);
      all_empty    <= (rd_idx_next[0] == wr_idx_next[0]) &&
                      (rd_lap_next[0] == wr_lap_next[0]) &&
                      (rd_idx_next[1] == wr_idx_next[1]) &&
                      (rd_lap_next[1] == wr_lap_next[1]);
    end
  end

`ifndef ASSERT_OFF
  // one operation in flight: an accepted word blocks the next accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input accepted while an operation is in flight");

  // the stamp moves only on a successful push
  a_stamp_push: assert property (@(posedge clk) disable iff (rst)
    (stamp != $past(stamp)) |-> ($past(exec_fire) && ($past(op_kind) == KIND_PUSH) &&
                                 ($past(status_next) == STATUS_OK)))
    else $error("arrival stamp moved outside a successful push");

  // a failed operation returns no item
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STATUS_OK)) |-> (popped_data == '0) && !popped_class)
    else $error("failed operation returned an item");

  // the flags agree with each other
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (all_empty == (class0_empty && class1_empty)))
    else $error("empty flags disagree");
`endif

endmodule
